### rtl/acc7seg_pkg.sv
// shared types, codes and display constants for the accelerometer seven-segment scanner
// no dependencies; imported by every module of the block
`default_nettype none

package acc7seg_pkg;

    // event kinds carried on the input tuser
    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_SCAN   = 2'd1,
        OP_BUTTON = 2'd2
    } t_op;

    // axis select codes
    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    // display positions in scan order
    typedef enum logic [1:0] {
        POS_SIGN     = 2'd0,
        POS_HUNDREDS = 2'd1,
        POS_TENS     = 2'd2,
        POS_UNITS    = 2'd3
    } t_pos;

    localparam int RAW_W    = 8;
    localparam int TENTHS_W = 8;
    localparam int WORD_W   = 16;

    // scaling: tenths = round((196 * raw - 24990) / 255)
    localparam logic [7:0]  SCALE_MUL = 8'd196;
    localparam logic [15:0] SCALE_OFS = 16'd24990;
    localparam logic [15:0] ROUND_ADD = 16'd255;
    // ceil(2^25 / 510), exact floor for numerators below 2^16
    localparam logic [16:0] RECIP_510 = 17'd65794;
    localparam int          RECIP_SH  = 25;

    // digit selects and segment codes, active low once inverted
    localparam logic [15:0] SEL_SIGN     = 16'h0800;
    localparam logic [15:0] SEL_HUNDREDS = 16'h0400;
    localparam logic [15:0] SEL_TENS     = 16'h0200;
    localparam logic [15:0] SEL_UNITS    = 16'h0100;
    localparam logic [15:0] DP_BIT       = 16'h0080;
    localparam logic [15:0] SEG_MINUS    = 16'h00FE;
    localparam logic [15:0] SEG_BLANK    = 16'h00FF;

    // decimal digit to segment code
    function automatic logic [15:0] seg_code(input logic [3:0] digit);
        logic [15:0] code;
        case (digit)
            4'd0:    code = 16'h0081;
            4'd1:    code = 16'h00E7;
            4'd2:    code = 16'h00A8;
            4'd3:    code = 16'h00A4;
            4'd4:    code = 16'h00C6;
            4'd5:    code = 16'h0094;
            4'd6:    code = 16'h0090;
            4'd7:    code = 16'h00A7;
            4'd8:    code = 16'h0080;
            4'd9:    code = 16'h0084;
            default: code = SEG_BLANK;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

### rtl/accel_seven_segment_scanner.sv
// top level of the accelerometer readout for a four-digit seven-segment display
// depends on acc7seg_pkg, acc7seg_conv and acc7seg_digit
`default_nettype none

// accelerometer readout scanner. each input item is one event, its kind on tuser:
// sample (0) latches the selected axis byte of tdata as signed tenths of m/s^2,
// round((196*raw-24990)/255), range -98..98; scan tick (1) returns one item with
// the active-low port word for the next digit (sign, hundreds, tens with decimal
// point, units, then round again); axis button (2) steps the select x, y, z, x.
// kind 3 is dropped silently. every item passes through the input register and a
// scan result then through the output register; one item is accepted every clock
// while the output side keeps up. the limit is the output register: a scan tick
// waits in the input register while an untaken result holds it. reset clears the
// latched value, the axis select and the scan position to zero.

module accel_seven_segment_scanner (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input item stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,   // x_raw[7:0], y_raw[15:8], z_raw[23:16]
    input  wire logic [1:0]  i_s_tuser,   // op[1:0]
    // result stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [15:0] o_m_tdata    // port_word[15:0]
);
    import acc7seg_pkg::*;

    // input register
    logic                r_in_valid;
    logic [1:0]          r_op;
    logic [RAW_W-1:0]    r_x_raw;
    logic [RAW_W-1:0]    r_y_raw;
    logic [RAW_W-1:0]    r_z_raw;

    // block state
    logic [TENTHS_W-1:0] r_shown_tenths;
    logic [TENTHS_W-1:0] n_shown_tenths;
    t_axis               r_axis;
    t_axis               n_axis;
    t_pos                r_pos;
    t_pos                n_pos;

    // output register
    logic                r_out_valid;
    logic                n_out_valid;
    logic [WORD_W-1:0]   r_out_word;
    logic [WORD_W-1:0]   n_out_word;

    logic                w_is_scan;
    logic                w_advance;
    logic [RAW_W-1:0]    w_sel_raw;
    logic [TENTHS_W-1:0] w_tenths;
    logic [WORD_W-1:0]   w_word;

    // a scan tick needs a free output slot, other kinds always move on
    assign w_is_scan  = (t_op'(r_op) == OP_SCAN);
    assign w_advance  = r_in_valid && (!w_is_scan || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_advance;

    // an unreachable select of three reads the x byte
    always_comb begin
        case (r_axis)
            AXIS_Y:  w_sel_raw = r_y_raw;
            AXIS_Z:  w_sel_raw = r_z_raw;
            default: w_sel_raw = r_x_raw;
        endcase
    end

    acc7seg_conv u_conv (
        .i_raw    (w_sel_raw),
        .o_tenths (w_tenths)
    );

    acc7seg_digit u_digit (
        .i_tenths (r_shown_tenths),
        .i_pos    (r_pos),
        .o_word   (w_word)
    );

    always_comb begin
        n_shown_tenths = r_shown_tenths;
        n_axis         = r_axis;
        n_pos          = r_pos;
        n_out_word     = r_out_word;
        n_out_valid    = r_out_valid && !i_m_tready;
        if (w_advance) begin
            case (t_op'(r_op))
                OP_SAMPLE: begin
                    n_shown_tenths = w_tenths;
                end
                OP_BUTTON: begin
                    case (r_axis)
                        AXIS_X:  n_axis = AXIS_Y;
                        AXIS_Y:  n_axis = AXIS_Z;
                        default: n_axis = AXIS_X;
                    endcase
                end
                OP_SCAN: begin
                    n_out_word  = w_word;
                    n_out_valid = 1'b1;
                    n_pos       = t_pos'(r_pos + 2'd1);
                end
                default: begin
                    // unused kind, nothing changes
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_shown_tenths <= '0;
            r_axis         <= AXIS_X;
            r_pos          <= POS_SIGN;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            r_out_valid    <= n_out_valid;
            r_shown_tenths <= n_shown_tenths;
            r_axis         <= n_axis;
            r_pos          <= n_pos;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_op    <= i_s_tuser;
            r_x_raw <= i_s_tdata[7:0];
            r_y_raw <= i_s_tdata[15:8];
            r_z_raw <= i_s_tdata[23:16];
        end
        r_out_word <= n_out_word;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_word;

endmodule

`default_nettype wire

### rtl/acc7seg_conv.sv
// raw sensor byte to signed tenths of m/s^2, rounded half away from zero
// depends on acc7seg_pkg
`default_nettype none

module acc7seg_conv (
    input  wire logic [acc7seg_pkg::RAW_W-1:0]    i_raw,
    output logic      [acc7seg_pkg::TENTHS_W-1:0] o_tenths
);
    import acc7seg_pkg::*;

    logic [15:0] w_scaled;
    logic        w_neg;
    logic [15:0] w_abs;
    logic [15:0] w_num;
    logic [32:0] w_prod;
    logic [6:0]  w_quot;

    // 196 = 128 + 64 + 4, shift-add only
    assign w_scaled = (16'(i_raw) << 7) + (16'(i_raw) << 6) + (16'(i_raw) << 2);
    assign w_neg    = (w_scaled < SCALE_OFS);
    assign w_abs    = w_neg ? (SCALE_OFS - w_scaled) : (w_scaled - SCALE_OFS);
    // (2|n| + 255) / 510 by reciprocal
    assign w_num    = (w_abs << 1) + ROUND_ADD;
    assign w_prod   = 33'(w_num) * 33'(RECIP_510);
    assign w_quot   = w_prod[RECIP_SH+6:RECIP_SH];

    assign o_tenths = w_neg ? (8'd0 - 8'(w_quot)) : 8'(w_quot);

endmodule

`default_nettype wire

### rtl/acc7seg_digit.sv
// one display digit: digit split of the latched value and segment lookup
// depends on acc7seg_pkg
`default_nettype none

module acc7seg_digit (
    input  wire logic [acc7seg_pkg::TENTHS_W-1:0] i_tenths,
    input  wire acc7seg_pkg::t_pos                i_pos,
    output logic      [acc7seg_pkg::WORD_W-1:0]   o_word
);
    import acc7seg_pkg::*;

    logic        w_neg;
    logic [7:0]  w_mag;
    logic [13:0] w_h_prod;
    logic [1:0]  w_hund;
    logic [7:0]  w_rem;
    logic [14:0] w_t_prod;
    logic [3:0]  w_tens;
    logic [7:0]  w_units;

    assign w_neg    = i_tenths[TENTHS_W-1];
    assign w_mag    = w_neg ? (8'd0 - i_tenths) : i_tenths;
    // mag / 100 as (mag * 41) >> 12, exact up to 128
    assign w_h_prod = 14'(w_mag) * 14'd41;
    assign w_hund   = w_h_prod[13:12];
    assign w_rem    = w_mag - 8'(w_hund) * 8'd100;
    // rem / 10 as (rem * 205) >> 11, exact below 100
    assign w_t_prod = 15'(w_rem) * 15'd205;
    assign w_tens   = w_t_prod[14:11];
    assign w_units  = w_rem - 8'(w_tens) * 8'd10;

    always_comb begin
        case (i_pos)
            POS_SIGN:     o_word = ~(SEL_SIGN | (w_neg ? SEG_MINUS : SEG_BLANK));
            POS_HUNDREDS: o_word = ~(SEL_HUNDREDS | seg_code(4'(w_hund)));
            POS_TENS:     o_word = ~(SEL_TENS | seg_code(w_tens)) ^ DP_BIT;
            POS_UNITS:    o_word = ~(SEL_UNITS | seg_code(w_units[3:0]));
            default:      o_word = ~(SEL_SIGN | SEG_BLANK);
        endcase
    end

endmodule

`default_nettype wire

### verif/tb_accel_seven_segment_scanner.sv
// self-checking testbench for the accelerometer seven-segment scanner
// drives sample, scan tick and axis button items and checks every port word
// depends on acc7seg_pkg and accel_seven_segment_scanner
`default_nettype none

module tb_accel_seven_segment_scanner;
    import acc7seg_pkg::*;

    // kind 3 has no member in the package enum; the block drops it
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // a result passes the input and output registers behind its tick, so a short drain is plenty
    localparam int DRAIN_CYCLES  = 8;
    // well above the longest receiver stall and the longest sender gap
    localparam int WATCHDOG_MAX  = 2000;
    localparam int RANDOM_CHUNKS = 4;
    localparam int CHUNK_ITEMS   = 250;

    // segment patterns for the decimal digits, before inversion
    localparam logic [15:0] DIGIT_SEGMENTS [10] = '{
        16'h0081, 16'h00E7, 16'h00A8, 16'h00A4, 16'h00C6,
        16'h0094, 16'h0090, 16'h00A7, 16'h0080, 16'h0084
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata = '0;   // x_raw[7:0], y_raw[15:8], z_raw[23:16]
    logic [1:0]  i_s_tuser = '0;   // op[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;        // port_word[15:0]

    accel_seven_segment_scanner dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // 4 unit period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // display predictor: own copy of latched value, axis and scan position
    // ------------------------------------------------------------------
    logic [7:0]  model_tenths = '0;
    t_axis       model_axis = AXIS_X;
    t_pos        model_pos = POS_SIGN;
    logic [15:0] expected_words [$];
    int          error_count = 0;

    // raw byte to tenths of m/s^2, rounded half away from zero
    function automatic logic [7:0] tenths_from_raw(input logic [7:0] raw);
        int num;
        int quot;
        num = 196 * int'(raw) - 24990;
        if (num >= 0) begin
            quot = (2 * num + 255) / 510;
        end else begin
            quot = -((-2 * num + 255) / 510);
        end
        return quot[7:0];
    endfunction

    // active-low port word for one display position
    function automatic logic [15:0] display_word(input t_pos pos, input logic [7:0] tenths);
        logic       neg;
        logic [7:0] mag;
        logic [15:0] word;
        neg = tenths[7];
        mag = neg ? 8'(-tenths) : tenths;
        case (pos)
            POS_SIGN:     word = ~(SEL_SIGN | (neg ? SEG_MINUS : SEG_BLANK));
            POS_HUNDREDS: word = ~(SEL_HUNDREDS | DIGIT_SEGMENTS[(mag / 100) % 10]);
            // tens digit carries the decimal point, set by flipping its bit high
            POS_TENS:     word = ~(SEL_TENS | DIGIT_SEGMENTS[(mag % 100) / 10]) ^ DP_BIT;
            default:      word = ~(SEL_UNITS | DIGIT_SEGMENTS[mag % 10]);
        endcase
        return word;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // one process both checks results and tracks accepted items; a result
    // can never belong to an item taken at the same edge
    always @(posedge i_clk) begin
        logic [7:0] raw;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("port_word with nothing pending", o_m_tdata, 16'h0000);
                end else begin
                    if (o_m_tdata !== expected_words[0])
                        report_mismatch("port_word", o_m_tdata, expected_words[0]);
                    void'(expected_words.pop_front());
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                case (i_s_tuser)
                    OP_SAMPLE: begin
                        case (model_axis)
                            AXIS_Y:  raw = i_s_tdata[15:8];
                            AXIS_Z:  raw = i_s_tdata[23:16];
                            default: raw = i_s_tdata[7:0];
                        endcase
                        model_tenths = tenths_from_raw(raw);
                    end
                    OP_SCAN: begin
                        expected_words.push_back(display_word(model_pos, model_tenths));
                        model_pos = t_pos'(model_pos + 2'd1);
                    end
                    OP_BUTTON: begin
                        model_axis = (model_axis == AXIS_Z) ? AXIS_X : t_axis'(model_axis + 2'd1);
                    end
                    default: ;  // unused kind: no effect at all
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random runs of ready and stall, with the odd long stall
    // ------------------------------------------------------------------
    int ready_run_left = 0;

    always @(posedge i_clk) begin
        int pick;
        if (ready_run_left == 0) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                i_m_tready     <= 1'b1;
                ready_run_left <= $urandom_range(1, 30);
            end else if (pick < 9) begin
                i_m_tready     <= 1'b0;
                ready_run_left <= $urandom_range(1, 6);
            end else begin
                i_m_tready     <= 1'b0;
                ready_run_left <= $urandom_range(20, 40);
            end
        end else begin
            ready_run_left <= ready_run_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any item moving on either side
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= WATCHDOG_MAX) begin
                $display("watchdog expired after %0d idle cycles", WATCHDOG_MAX);
                $display("accel_seven_segment_scanner test failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // sender: bursts of random length, random gaps between bursts
    // ------------------------------------------------------------------
    int burst_left = 0;
    bit gaps_enabled = 1'b1;

    task automatic send_event(input logic [1:0] kind, input logic [7:0] x_raw,
                              input logic [7:0] y_raw, input logic [7:0] z_raw);
        int gap;
        if (burst_left == 0) begin
            gap = 0;
            if (gaps_enabled && $urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 8);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {z_raw, y_raw, x_raw};
        i_s_tuser  <= kind;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        burst_left--;
    endtask

    task automatic send_scans(input int count);
        repeat (count) send_event(OP_SCAN, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // straight after reset the display reads plus zero point zero
    task automatic test_reset_display();
        send_scans(4);
    endtask

    // each axis with an extreme byte, the others set to tell it apart;
    // also walks the button through x, y, z and back round to x
    task automatic test_axis_extremes();
        send_event(OP_SAMPLE, 8'd0, 8'd255, 8'd128);     // x at -9.8
        send_scans(4);
        send_event(OP_BUTTON, 8'hFF, 8'hFF, 8'hFF);
        send_event(OP_SAMPLE, 8'd128, 8'd255, 8'd0);     // y at +9.8
        send_scans(3);
        send_event(OP_BUTTON, 8'h00, 8'h00, 8'h00);
        send_event(OP_SAMPLE, 8'd255, 8'd0, 8'd128);     // z just above zero rounds to 0
        send_scans(3);
        // button from z wraps the select back to x
        send_event(OP_BUTTON, 8'hA5, 8'h5A, 8'hC3);
        send_event(OP_SAMPLE, 8'd127, 8'd0, 8'd255);     // x just below zero rounds to 0
        send_scans(2);
    endtask

    // the unused kind must neither latch, step the axis nor return an item
    task automatic test_unused_kind();
        send_event(OP_UNUSED, 8'd0, 8'd255, 8'd0);
        send_scans(2);
    endtask

    // long mixed traffic; one chunk runs the sender without gaps
    task automatic test_random_traffic();
        int pick;
        for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
            gaps_enabled = (chunk != 2);
            for (int n = 0; n < CHUNK_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                    send_event(OP_SAMPLE, 8'($urandom), 8'($urandom), 8'($urandom));
                else if (pick < 85)
                    send_scans(1);
                else if (pick < 95)
                    send_event(OP_BUTTON, 8'($urandom), 8'($urandom), 8'($urandom));
                else
                    send_event(OP_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom));
            end
        end
        gaps_enabled = 1'b1;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_display();
        test_axis_extremes();
        test_unused_kind();
        test_random_traffic();
        i_s_tvalid <= 1'b0;

        // let every pending port word come out, then a short quiet spell
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && expected_words.size() == 0) begin
            $display("accel_seven_segment_scanner test passed");
        end else begin
            $display("accel_seven_segment_scanner test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
